/* design/varm_pkg.sv */
// ----------------------------------------------------------------------------
// varm_pkg: shared constants, widths and helpers for the alignment core
// Fixed-point formats, pipeline depths and the rounding product used by the assembly stages.
// ----------------------------------------------------------------------------
package varm_pkg;

	localparam int CoordW = 24;
	localparam int FracW  = 16;
	localparam int OutW   = FracW + 2;
	localparam int XW     = 2 * CoordW + 1;        // raw cross product width
	localparam int UW     = FracW + 2;             // unit component, signed
	localparam int MW     = 31;                    // normalised magnitude
	localparam int SqW    = 64;
	localparam int RW     = 32;                    // sqrt result
	localparam int QuoW   = MW + FracW + 1;
	localparam int PW     = 2 * UW + 2;            // product width in the assembly
	localparam int WW     = UW + 2;                // cosine, 1 - cosine, scaled axis

	// unit-vector unit: alignment, squares, root bits, quotient bits
	localparam int NormLat = 2 + RW + QuoW;
	// valid line: input register, unit-vector unit, three assembly stages
	localparam int Lat     = 1 + NormLat + 3;

	typedef logic signed [UW-1:0]  unit_t;
	typedef logic [MW-1:0]         nmag_t;

	// rounding product back to Q.F, half away from zero
	function automatic logic signed [2*UW+1:0] fx_round(input logic signed [2*UW+1:0] p);
		logic [2*UW+1:0] m;
		logic [2*UW+1:0] r;
		begin
			m = p[2*UW+1] ? (~p + 1'b1) : p;
			r = (m + ((2*UW+2)'(1) << (FracW - 1))) >> FracW;
			fx_round = p[2*UW+1] ? (~r + 1'b1) : r;
		end
	endfunction

	function automatic logic signed [OutW-1:0] sat_out(input logic signed [2*UW+3:0] x);
		begin
			if (x > (2*UW+4)'(signed'(1 <<< FracW)))
				sat_out = OutW'(1 <<< FracW);
			else if (x < -(2*UW+4)'(signed'(1 <<< FracW)))
				sat_out = OutW'(-(1 <<< FracW));
			else
				sat_out = x[OutW-1:0];
		end
	endfunction

endpackage

/* design/varm_norm.sv */
// ----------------------------------------------------------------------------
// varm_norm: pipelined unit-vector unit
// Aligns magnitudes, squares, square-roots bit by bit and divides bit by bit,
// one stage per result bit.
// ----------------------------------------------------------------------------
module varm_norm (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [varm_pkg::XW-1:0]    vx,
	input  logic signed [varm_pkg::XW-1:0]    vy,
	input  logic signed [varm_pkg::XW-1:0]    vz,
	output varm_pkg::unit_t                   ux,
	output varm_pkg::unit_t                   uy,
	output varm_pkg::unit_t                   uz
);
	import varm_pkg::*;

	// stage 1: magnitudes and alignment
	logic [XW-1:0] ma, mb, mc, mx;
	nmag_t         na, nb, nc;
	logic [6:0]    lz;
	always_comb begin
		ma = vx[XW-1] ? XW'(-vx) : XW'(vx);
		mb = vy[XW-1] ? XW'(-vy) : XW'(vy);
		mc = vz[XW-1] ? XW'(-vz) : XW'(vz);
		mx = ma | mb | mc;
		lz = 7'd0;
		for (int i = 0; i < XW; i++)
			if (mx[i]) lz = 7'(i);
		if (lz >= 7'd30) begin
			na = MW'(ma >> (lz - 7'd30));
			nb = MW'(mb >> (lz - 7'd30));
			nc = MW'(mc >> (lz - 7'd30));
		end else begin
			na = MW'(ma << (7'd30 - lz));
			nb = MW'(mb << (7'd30 - lz));
			nc = MW'(mc << (7'd30 - lz));
		end
	end

	nmag_t      a_s1, b_s1, c_s1;
	logic [2:0] neg_s1;
	logic       zero_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= na;
			b_s1    <= nb;
			c_s1    <= nc;
			neg_s1  <= {vz[XW-1], vy[XW-1], vx[XW-1]};
			zero_s1 <= (mx == '0);
		end
	end

	typedef struct packed {
		logic [MW-1:0] a, b, c;
		logic [2:0]    neg;
		logic          zero;
		logic [SqW-1:0] rem;
		logic [RW-1:0]  root;
	} sq_t;

	// restoring square root, one result bit a stage
	function automatic sq_t sq_step(input sq_t s, input int g);
		sq_t            o;
		logic [SqW-1:0] trial;
		begin
			o     = s;
			trial = (SqW'(s.root) << (RW - g)) + (SqW'(1) << (2*(RW - 1 - g)));
			if (s.rem >= trial) begin
				o.rem  = s.rem - trial;
				o.root = s.root | (RW'(1) << (RW - 1 - g));
			end
			sq_step = o;
		end
	endfunction

	// stage 2: sum of squares
	sq_t sq_in;
	always_comb begin
		sq_in.a    = a_s1;
		sq_in.b    = b_s1;
		sq_in.c    = c_s1;
		sq_in.neg  = neg_s1;
		sq_in.zero = zero_s1;
		sq_in.rem  = SqW'(a_s1) * SqW'(a_s1) + SqW'(b_s1) * SqW'(b_s1)
		             + SqW'(c_s1) * SqW'(c_s1);
		sq_in.root = '0;
	end

	sq_t sq_s [0:RW];
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0] <= sq_in;
			for (int g = 0; g < RW; g++)
				sq_s[g+1] <= sq_step(sq_s[g], g);
		end
	end

	// restoring divide of three numerators by the root
	typedef struct packed {
		logic [2:0]            neg;
		logic                  zero;
		logic [RW-1:0]         d;
		logic [2:0][QuoW-1:0]  num;
		logic [2:0][RW:0]      rm;
		logic [2:0][QuoW-1:0]  quo;
	} dv_t;

	function automatic dv_t dv_step(input dv_t s, input int g);
		dv_t         o;
		logic [RW:0] sh;
		begin
			o = s;
			for (int j = 0; j < 3; j++) begin
				sh = {s.rm[j][RW-1:0], s.num[j][QuoW-1-g]};
				if (sh >= (RW+1)'(s.d)) begin
					o.rm[j]  = sh - (RW+1)'(s.d);
					o.quo[j] = s.quo[j] | (QuoW'(1) << (QuoW - 1 - g));
				end else begin
					o.rm[j]  = sh;
				end
			end
			dv_step = o;
		end
	endfunction

	dv_t dv_in;
	always_comb begin
		dv_in.neg    = sq_s[RW].neg;
		dv_in.zero   = sq_s[RW].zero;
		dv_in.d      = (sq_s[RW].root == '0) ? RW'(1) : sq_s[RW].root;
		dv_in.num[0] = (QuoW'(sq_s[RW].a) << FracW) + QuoW'(sq_s[RW].root >> 1);
		dv_in.num[1] = (QuoW'(sq_s[RW].b) << FracW) + QuoW'(sq_s[RW].root >> 1);
		dv_in.num[2] = (QuoW'(sq_s[RW].c) << FracW) + QuoW'(sq_s[RW].root >> 1);
		dv_in.rm     = '0;
		dv_in.quo    = '0;
	end

	dv_t dv_s [0:QuoW-1];
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dv_step(dv_in, 0);
			for (int g = 1; g < QuoW; g++)
				dv_s[g] <= dv_step(dv_s[g-1], g);
		end
	end

	unit_t q0, q1, q2;
	always_comb begin
		q0 = UW'(dv_s[QuoW-1].quo[0]);
		q1 = UW'(dv_s[QuoW-1].quo[1]);
		q2 = UW'(dv_s[QuoW-1].quo[2]);
		ux = dv_s[QuoW-1].zero ? '0 : (dv_s[QuoW-1].neg[0] ? -q0 : q0);
		uy = dv_s[QuoW-1].zero ? '0 : (dv_s[QuoW-1].neg[1] ? -q1 : q1);
		uz = dv_s[QuoW-1].zero ? '0 : (dv_s[QuoW-1].neg[2] ? -q2 : q2);
	end
endmodule

/* design/varm_matrix.sv */
// ----------------------------------------------------------------------------
// varm_matrix: Rodrigues assembly
// Cosine, sine vector, scaled axis and entries over three register stages.
// ----------------------------------------------------------------------------
module varm_matrix (
	input  logic                               clk,
	input  logic                               en,
	input  varm_pkg::unit_t                    bx, by, bz,
	input  varm_pkg::unit_t                    ax, ay, az,
	input  varm_pkg::unit_t                    kx, ky, kz,
	output logic signed [varm_pkg::OutW-1:0]   e [0:8]
);
	import varm_pkg::*;

	typedef logic signed [PW-1:0] p_t;
	typedef logic signed [WW-1:0] w_t;

	function automatic p_t mr(input unit_t a, input unit_t b);
		p_t p;
		begin
			p = p_t'(a) * p_t'(b);
			mr = fx_round(p);
		end
	endfunction

	w_t c_s1;
	p_t s0_s1, s1_s1, s2_s1;
	unit_t k0_s1, k1_s1, k2_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= w_t'(fx_round(p_t'(bx)*p_t'(ax) + p_t'(by)*p_t'(ay)
			                       + p_t'(bz)*p_t'(az)));
			s0_s1 <= mr(by, az) - mr(bz, ay);
			s1_s1 <= mr(bz, ax) - mr(bx, az);
			s2_s1 <= mr(bx, ay) - mr(by, ax);
			k0_s1 <= kx; k1_s1 <= ky; k2_s1 <= kz;
		end
	end

	w_t t;
	assign t = w_t'(1 <<< FracW) - c_s1;
	w_t q0_s2, q1_s2, q2_s2, c_s2;
	p_t s0_s2, s1_s2, s2_s2;
	unit_t k0_s2, k1_s2, k2_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			q0_s2 <= w_t'(fx_round(p_t'(k0_s1) * p_t'(t)));
			q1_s2 <= w_t'(fx_round(p_t'(k1_s1) * p_t'(t)));
			q2_s2 <= w_t'(fx_round(p_t'(k2_s1) * p_t'(t)));
			c_s2 <= c_s1; s0_s2 <= s0_s1; s1_s2 <= s1_s1; s2_s2 <= s2_s1;
			k0_s2 <= k0_s1; k1_s2 <= k1_s1; k2_s2 <= k2_s1;
		end
	end

	p_t d0_s3, d1_s3, d2_s3, pxy_s3, pzx_s3, pyz_s3, s0_s3, s1_s3, s2_s3;
	w_t c_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			d0_s3  <= fx_round(p_t'(q0_s2) * p_t'(k0_s2));
			d1_s3  <= fx_round(p_t'(q1_s2) * p_t'(k1_s2));
			d2_s3  <= fx_round(p_t'(q2_s2) * p_t'(k2_s2));
			pxy_s3 <= fx_round(p_t'(q0_s2) * p_t'(k1_s2));
			pzx_s3 <= fx_round(p_t'(q2_s2) * p_t'(k0_s2));
			pyz_s3 <= fx_round(p_t'(q1_s2) * p_t'(k2_s2));
			c_s3 <= c_s2; s0_s3 <= s0_s2; s1_s3 <= s1_s2; s2_s3 <= s2_s2;
		end
	end

	always_comb begin
		e[0] = sat_out((PW+2)'(d0_s3) + (PW+2)'(c_s3));
		e[1] = sat_out((PW+2)'(pxy_s3) - (PW+2)'(s2_s3));
		e[2] = sat_out((PW+2)'(pzx_s3) + (PW+2)'(s1_s3));
		e[3] = sat_out((PW+2)'(pxy_s3) + (PW+2)'(s2_s3));
		e[4] = sat_out((PW+2)'(d1_s3) + (PW+2)'(c_s3));
		e[5] = sat_out((PW+2)'(pyz_s3) - (PW+2)'(s0_s3));
		e[6] = sat_out((PW+2)'(pzx_s3) - (PW+2)'(s1_s3));
		e[7] = sat_out((PW+2)'(pyz_s3) + (PW+2)'(s0_s3));
		e[8] = sat_out((PW+2)'(d2_s3) + (PW+2)'(c_s3));
	end
endmodule

/* design/vector_alignment_rotation_matrix_core.sv */
// ----------------------------------------------------------------------------
// vector_alignment_rotation_matrix_core: rotation taking one direction to another
// Rodrigues matrix from two Q8.16 vectors, Q2.16 entries, identity when parallel, antiparallel or zero.
// ----------------------------------------------------------------------------
// Channel   Handshake          Payload
// request   start / busy       before_x..z, after_x..z (24 b signed)
// result    done (one cycle)   m00..m22 (18 b signed), degenerate
//
// One request per cycle; busy is tied low as the pipeline never stalls.
// The path runs through the input register, alignment and squares, then the
// bit-serial square root (one root bit a stage) and divider (one quotient bit a
// stage), the assembly and the output register.
// Reset clears only the valid line and done; the receiver cannot hold results off.
// ----------------------------------------------------------------------------
module vector_alignment_rotation_matrix_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [varm_pkg::CoordW-1:0]   before_x, before_y, before_z,
	input  logic signed [varm_pkg::CoordW-1:0]   after_x, after_y, after_z,
	output logic                                 done,
	output logic signed [varm_pkg::OutW-1:0]     m00, m01, m02, m10, m11, m12,
	output logic signed [varm_pkg::OutW-1:0]     m20, m21, m22,
	output logic                                 degenerate
);
	import varm_pkg::*;

	assign busy = 1'b0;

	// stage 1: register request, exact cross product
	logic signed [CoordW-1:0] b0_s1, b1_s1, b2_s1, a0_s1, a1_s1, a2_s1;
	logic signed [XW-1:0]     x0_s1, x1_s1, x2_s1;
	always_ff @(posedge clk) begin
		b0_s1 <= before_x; b1_s1 <= before_y; b2_s1 <= before_z;
		a0_s1 <= after_x;  a1_s1 <= after_y;  a2_s1 <= after_z;
		x0_s1 <= XW'(before_y) * XW'(after_z) - XW'(before_z) * XW'(after_y);
		x1_s1 <= XW'(before_z) * XW'(after_x) - XW'(before_x) * XW'(after_z);
		x2_s1 <= XW'(before_x) * XW'(after_y) - XW'(before_y) * XW'(after_x);
	end

	// all three unit-vector units share one width, inputs sign-extended
	unit_t ub0, ub1, ub2, ua0, ua1, ua2, k0, k1, k2;
	varm_norm u_nb (.clk, .en(1'b1),
		.vx(XW'(b0_s1)), .vy(XW'(b1_s1)), .vz(XW'(b2_s1)), .ux(ub0), .uy(ub1), .uz(ub2));
	varm_norm u_na (.clk, .en(1'b1),
		.vx(XW'(a0_s1)), .vy(XW'(a1_s1)), .vz(XW'(a2_s1)), .ux(ua0), .uy(ua1), .uz(ua2));
	varm_norm u_nk (.clk, .en(1'b1),
		.vx(x0_s1), .vy(x1_s1), .vz(x2_s1), .ux(k0), .uy(k1), .uz(k2));

	logic signed [OutW-1:0] e [0:8];
	varm_matrix u_mx (.clk, .en(1'b1), .bx(ub0), .by(ub1), .bz(ub2),
		.ax(ua0), .ay(ua1), .az(ua2), .kx(k0), .ky(k1), .kz(k2), .e);

	// valid and degenerate flag travel alongside
	logic [Lat-1:0] vld_q;
	logic [Lat-1:0] dg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Lat-2:0], start};
		end
	end
	always_ff @(posedge clk) begin
		dg_q <= {dg_q[Lat-2:0],
		         (XW'(before_y) * XW'(after_z) == XW'(before_z) * XW'(after_y)) &&
		         (XW'(before_z) * XW'(after_x) == XW'(before_x) * XW'(after_z)) &&
		         (XW'(before_x) * XW'(after_y) == XW'(before_y) * XW'(after_x))};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[Lat-1];
		end
	end
	always_ff @(posedge clk) begin
		degenerate <= dg_q[Lat-1];
		if (dg_q[Lat-1]) begin
			m00 <= OutW'(1 << FracW); m11 <= OutW'(1 << FracW); m22 <= OutW'(1 << FracW);
			m01 <= '0; m02 <= '0; m10 <= '0; m12 <= '0; m20 <= '0; m21 <= '0;
		end else begin
			m00 <= e[0]; m01 <= e[1]; m02 <= e[2];
			m10 <= e[3]; m11 <= e[4]; m12 <= e[5];
			m20 <= e[6]; m21 <= e[7]; m22 <= e[8];
		end
	end
endmodule

/* bench/tb_vector_alignment_rotation_matrix_core.sv */
// ----------------------------------------------------------------------------
// tb_vector_alignment_rotation_matrix_core: self-checking bench for the core
// Drives vector pairs in bursts, predicts each Rodrigues matrix in 64-bit
// integer arithmetic and checks every result, in order, field by field.
// ----------------------------------------------------------------------------
module tb_vector_alignment_rotation_matrix_core;
	import varm_pkg::*;

	localparam int Latency = 1 + 2 + 32 + 48 + 3 + 1;
	localparam longint OneFx = longint'(1) << FracW;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [OutW-1:0]   entry_t;

	// one result: nine entries row-major, then the degenerate flag
	typedef struct {
		entry_t m [9];
		logic   degen;
	} matrix_t;

	// --------------------------------------------------------------------
	// Rotation predictor
	// --------------------------------------------------------------------
	function automatic longint mul_round(longint a, longint b);
		longint p;
		longint unsigned m;
		p = a * b;
		m = ((p < 0) ? longint'(-p) : p) + (longint'(1) << (FracW - 1));
		m = m >> FracW;
		return (p < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res  = 0;
		bitv = longint'(1) << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// unit vector in Q.F; magnitudes normalised so the largest is in [2^30, 2^31)
	function automatic void unit_vec(input longint v [3], output longint u [3]);
		longint unsigned m [3];
		longint unsigned mx, n, r;
		mx = 0;
		n  = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++)
				u[i] = 0;
			return;
		end
		while (mx >= (longint'(1) << 31)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++)
				m[i] = m[i] >> 1;
		end
		while (mx < (longint'(1) << 30)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++)
				m[i] = m[i] << 1;
		end
		for (int i = 0; i < 3; i++)
			n = n + m[i] * m[i];
		r = int_sqrt(n);
		for (int i = 0; i < 3; i++) begin
			longint unsigned quo;
			quo = ((m[i] << FracW) + (r >> 1)) / r;
			u[i] = (v[i] < 0) ? -longint'(quo) : longint'(quo);
		end
	endfunction

	function automatic entry_t clamp_entry(longint x);
		if (x > OneFx)
			x = OneFx;
		if (x < -OneFx)
			x = -OneFx;
		return entry_t'(x);
	endfunction

	function automatic matrix_t predict_rotation(coord_t bv [3], coord_t av [3]);
		matrix_t res;
		longint b [3], a [3], x [3], ub [3], ua [3], k [3], s [3], q [3];
		longint c, d, pxy, pzx, pyz;
		longint unsigned dm;
		for (int i = 0; i < 3; i++) begin
			b[i] = longint'(bv[i]);
			a[i] = longint'(av[i]);
		end
		x[0] = b[1] * a[2] - b[2] * a[1];
		x[1] = b[2] * a[0] - b[0] * a[2];
		x[2] = b[0] * a[1] - b[1] * a[0];
		// parallel, antiparallel or zero vector: identity, flagged
		if (x[0] == 0 && x[1] == 0 && x[2] == 0) begin
			for (int i = 0; i < 9; i++)
				res.m[i] = (i % 4 == 0) ? entry_t'(OneFx) : '0;
			res.degen = 1'b1;
			return res;
		end
		unit_vec(b, ub);
		unit_vec(a, ua);
		unit_vec(x, k);
		// cosine: one rounding over the whole dot product
		d  = ub[0] * ua[0] + ub[1] * ua[1] + ub[2] * ua[2];
		dm = ((d < 0) ? longint'(-d) : d) + (longint'(1) << (FracW - 1));
		dm = dm >> FracW;
		c  = (d < 0) ? -longint'(dm) : longint'(dm);
		s[0] = mul_round(ub[1], ua[2]) - mul_round(ub[2], ua[1]);
		s[1] = mul_round(ub[2], ua[0]) - mul_round(ub[0], ua[2]);
		s[2] = mul_round(ub[0], ua[1]) - mul_round(ub[1], ua[0]);
		for (int i = 0; i < 3; i++)
			q[i] = mul_round(k[i], OneFx - c);
		pxy = mul_round(q[0], k[1]);
		pzx = mul_round(q[2], k[0]);
		pyz = mul_round(q[1], k[2]);
		res.m[0] = clamp_entry(mul_round(q[0], k[0]) + c);
		res.m[1] = clamp_entry(pxy - s[2]);
		res.m[2] = clamp_entry(pzx + s[1]);
		res.m[3] = clamp_entry(pxy + s[2]);
		res.m[4] = clamp_entry(mul_round(q[1], k[1]) + c);
		res.m[5] = clamp_entry(pyz - s[0]);
		res.m[6] = clamp_entry(pzx - s[1]);
		res.m[7] = clamp_entry(pyz + s[0]);
		res.m[8] = clamp_entry(mul_round(q[2], k[2]) + c);
		res.degen = 1'b0;
		return res;
	endfunction

	// --------------------------------------------------------------------
	// Scoreboard: matrices still owed by the core, oldest first
	// --------------------------------------------------------------------
	class matrix_board;
		matrix_t pending [$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(coord_t bv [3], coord_t av [3]);
			pending = {pending, predict_rotation(bv, av)};
		endfunction

		function void check_result(matrix_t got);
			matrix_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, none pending", $time);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 9; i++)
				if (got.m[i] !== want.m[i]) begin
					$display("%0t: m%0d%0d expected %0d actual %0d", $time,
						i / 3, i % 3, want.m[i], got.m[i]);
					errors++;
				end
			if (got.degen !== want.degen) begin
				$display("%0t: degenerate expected %0b actual %0b", $time,
					want.degen, got.degen);
				errors++;
			end
		endfunction
	endclass

	// --------------------------------------------------------------------
	// DUT
	// --------------------------------------------------------------------
	logic   clk, arst_n, start, busy, done, degenerate;
	coord_t before_x, before_y, before_z, after_x, after_y, after_z;
	entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	vector_alignment_rotation_matrix_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.before_x(before_x), .before_y(before_y), .before_z(before_z),
		.after_x(after_x), .after_y(after_y), .after_z(after_z),
		.done(done),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.degenerate(degenerate)
	);

	matrix_board board = new();

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// sample both channels at the rising edge; inputs move only on the falling one
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_request('{before_x, before_y, before_z},
					'{after_x, after_y, after_z});
			if (done) begin
				matrix_t got;
				got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
				got.degen = degenerate;
				board.check_result(got);
			end
		end
	end

	// --------------------------------------------------------------------
	// Request driver
	// --------------------------------------------------------------------
	int burst_left;

	// present one request and hold it until the core takes it
	task automatic send_request(coord_t bx, by, bz, ax, ay, az);
		@(negedge clk);
		before_x = bx; before_y = by; before_z = bz;
		after_x  = ax; after_y  = ay; after_z  = az;
		start    = 1'b1;
		do
			@(posedge clk);
		while (busy);
		// end of a burst: drop start for a random gap
		if (burst_left <= 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 8))
				@(negedge clk);
			burst_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 24);
		end else begin
			burst_left--;
		end
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t rand_small(int lim);
		return coord_t'($signed($urandom_range(0, 2 * lim)) - lim);
	endfunction

	// a random well-formed pair, picked from several shapes
	task automatic send_random();
		coord_t v [3];
		int p, r;
		case ($urandom_range(0, 5))
			0, 1: send_request(rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord());
			2: send_request(rand_small(300), rand_small(300), rand_small(300),
				rand_small(300), rand_small(300), rand_small(300));
			3: begin
				// exactly parallel or antiparallel: scaled copies
				for (int i = 0; i < 3; i++)
					v[i] = rand_small(2000);
				p = $signed($urandom_range(0, 8000)) - 4000;
				r = $signed($urandom_range(0, 8000)) - 4000;
				send_request(coord_t'(v[0] * p), coord_t'(v[1] * p), coord_t'(v[2] * p),
					coord_t'(v[0] * r), coord_t'(v[1] * r), coord_t'(v[2] * r));
			end
			4: begin
				// nearly or exactly parallel, components at most one unit off
				for (int i = 0; i < 3; i++)
					v[i] = rand_small(4000000);
				send_request(v[0], v[1], v[2], v[0] + coord_t'($urandom_range(0, 1)),
					v[1], v[2] - coord_t'($urandom_range(0, 1)));
			end
			default: send_request(rand_coord(), 0, rand_small(5), 0, rand_coord(),
				rand_small(5));
		endcase
	endtask

	localparam coord_t CMax = coord_t'(8388607);
	localparam coord_t CMin = coord_t'(-8388608);
	localparam coord_t One  = coord_t'(65536);

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		before_x = '0; before_y = '0; before_z = '0;
		after_x  = '0; after_y  = '0; after_z  = '0;
		burst_left = 0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero vectors, parallel, antiparallel, axes, extremes
		send_request(0, 0, 0, 0, 0, 0);
		send_request(0, 0, 0, One, 0, 0);
		send_request(One, 0, 0, 0, 0, 0);
		send_request(One, 0, 0, 3 * One, 0, 0);
		send_request(One, 0, 0, -One, 0, 0);
		send_request(One, 0, 0, 0, One, 0);
		send_request(0, One, 0, 0, 0, One);
		send_request(0, 0, One, One, 0, 0);
		send_request(One, 0, 0, 0, -One, 0);
		send_request(CMax, CMax, CMax, CMin, CMin, CMin);
		send_request(CMin, CMin, CMin, CMin, CMin, CMin);
		send_request(CMax, 0, 0, 0, 0, CMin);
		send_request(CMin, CMax, CMin, CMax, CMin, CMax);
		send_request(CMax, CMax, CMax, CMax, CMax, CMax - 1);
		send_request(CMin, 0, 0, CMin, 1, 0);
		send_request(1, 0, 0, 0, 1, 0);
		send_request(1, 1, 1, -1, 1, -1);
		send_request(1, 0, 0, CMax, 1, 0);
		send_request(One, One, 0, -One, -One + 1, 0);
		send_request(-1, -1, -1, 1, 2, 3);
		send_request(CMax, 1, 0, -CMax, 0, 1);

		for (int n = 0; n < 700; n++) begin
			send_random();
			// hold off once mid-run until the pipeline has drained
			if (n == 350) begin
				@(negedge clk);
				start = 1'b0;
				while (board.pending.size() != 0)
					@(negedge clk);
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (Latency + 10)
			@(negedge clk);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
